// File: rtl/mfoc_pkg.sv
// Shared constants, operation and status codes, and interface structs for the
// message FIFO with overflow count. No dependencies; used by all rtl but mfoc_ram.
`timescale 1ns / 1ps

package mfoc_pkg;

	// Built storage and field widths.
	localparam int DEPTH   = 64;
	localparam int ELEM_W  = 64;
	localparam int DATA_W  = 64;
	localparam int QLEN_W  = 7;
	localparam int FILL_W  = 7;
	localparam int OP_W    = 2;
	localparam int ST_W    = 2;
	localparam int OVF_W   = 32;
	localparam int PTR_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int CMP_W   = (QLEN_W > CNT_W) ? QLEN_W : CNT_W;

	// Packed stream widths, rounded up to whole bytes.
	localparam int OUT_FIELDS_W = DATA_W + FILL_W + 1 + OVF_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [QLEN_W-1:0] QLEN_RESET = QLEN_W'(64);

	// Operation codes.
	localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
	localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
	localparam logic [OP_W-1:0] OP_RESET   = 2'd2;

	// Status codes.
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

	// Memory access issued by the controller.
	typedef struct packed {
		logic              we;
		logic [PTR_W-1:0]  waddr;
		logic [ELEM_W-1:0] wdata;
		logic              re;
		logic [PTR_W-1:0]  raddr;
	} ram_req_t;

	// Result fields known at accept time; data comes later from the memory.
	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic             rd_used;
		logic [CNT_W-1:0] fill;
		logic             ovf_seen;
		logic [OVF_W-1:0] ovf_total;
	} meta_t;

endpackage

// File: rtl/mfoc_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module mfoc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/mfoc_ctrl.sv
// Queue controller: pointers, fill count, overflow flag and counter, length
// register. Issues memory accesses. Depends on mfoc_pkg.
`timescale 1ns / 1ps

module mfoc_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [mfoc_pkg::OP_W-1:0]     operation,
	input  logic [mfoc_pkg::DATA_W-1:0]   data_in,
	input  logic                          cfg_we,
	input  logic [mfoc_pkg::QLEN_W-1:0]   cfg_wdata,
	output mfoc_pkg::ram_req_t            ram_req,
	output mfoc_pkg::meta_t               meta
);
	import mfoc_pkg::*;

	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;
	logic [OVF_W-1:0]  ovf_cnt_q;
	logic [QLEN_W-1:0] qlen_q;

	logic [PTR_W-1:0]  rd_ptr_d;
	logic [PTR_W-1:0]  wr_ptr_d;
	logic [CNT_W-1:0]  count_d;
	logic              ovf_d;
	logic [OVF_W-1:0]  ovf_cnt_d;
	logic [CMP_W-1:0]  len;
	logic [CMP_W-1:0]  qlen_x;
	logic [CMP_W-1:0]  count_x;
	logic [ST_W-1:0]   status;
	logic              do_write;
	logic              do_read;
	logic [PTR_W-1:0]  wr_addr;

	// Step a pointer, wrapping to zero at the effective length.
	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
		input logic [CMP_W-1:0] l);
		logic [CMP_W-1:0] n;
		n = CMP_W'(p) + CMP_W'(1);
		return (n >= l) ? '0 : n[PTR_W-1:0];
	endfunction

	// Effective length: zero acts as one, anything above the depth as the depth.
	always_comb begin
		qlen_x = CMP_W'(qlen_q);
		if (qlen_q == '0) begin
			len = CMP_W'(1);
		end else if (qlen_x > CMP_W'(DEPTH)) begin
			len = CMP_W'(DEPTH);
		end else begin
			len = qlen_x;
		end
	end

	// Next state and result for the operation at the input.
	always_comb begin
		count_x   = CMP_W'(count_q);
		rd_ptr_d  = rd_ptr_q;
		wr_ptr_d  = wr_ptr_q;
		count_d   = count_q;
		ovf_d     = ovf_q;
		ovf_cnt_d = ovf_cnt_q;
		status    = ST_OK;
		do_write  = 1'b0;
		do_read   = 1'b0;
		wr_addr   = wr_ptr_q;
		unique case (operation)
			OP_ENQUEUE: begin
				if (count_x < len) begin
					do_write = 1'b1;
					if (count_q != '0) begin
						wr_addr  = advance(wr_ptr_q, len);
						wr_ptr_d = wr_addr;
					end else begin
						rd_ptr_d = wr_ptr_q;
					end
					count_d = count_q + CNT_W'(1);
				end else begin
					ovf_d     = 1'b1;
					ovf_cnt_d = ovf_cnt_q + OVF_W'(1);
					status    = ST_FULL;
				end
			end
			OP_DEQUEUE: begin
				if (count_q != '0) begin
					do_read  = 1'b1;
					rd_ptr_d = advance(rd_ptr_q, len);
					count_d  = count_q - CNT_W'(1);
				end else begin
					status = ST_EMPTY;
				end
			end
			OP_RESET: begin
				rd_ptr_d  = '0;
				wr_ptr_d  = '0;
				count_d   = '0;
				ovf_d     = 1'b0;
				ovf_cnt_d = '0;
			end
			default: begin
			end
		endcase
	end

	// Memory access for this transaction.
	assign ram_req.we    = accept && do_write;
	assign ram_req.waddr = wr_addr;
	assign ram_req.wdata = ELEM_W'(data_in);
	assign ram_req.re    = accept && do_read;
	assign ram_req.raddr = rd_ptr_q;

	// Result fields as they stand after the operation.
	assign meta.status    = status;
	assign meta.rd_used   = do_read;
	assign meta.fill      = count_d;
	assign meta.ovf_seen  = ovf_d;
	assign meta.ovf_total = ovf_cnt_d;

	// Control state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q  <= '0;
			wr_ptr_q  <= '0;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			ovf_cnt_q <= '0;
		end else if (accept) begin
			rd_ptr_q  <= rd_ptr_d;
			wr_ptr_q  <= wr_ptr_d;
			count_q   <= count_d;
			ovf_q     <= ovf_d;
			ovf_cnt_q <= ovf_cnt_d;
		end
	end

	// Length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlen_q <= QLEN_RESET;
		end else if (cfg_we) begin
			qlen_q <= cfg_wdata;
		end
	end

endmodule

// File: rtl/message_fifo_with_overflow_count.sv
// Top level of the message FIFO with overflow count: stream ports, memory
// pipeline stage and output register. Depends on mfoc_pkg, mfoc_ctrl, mfoc_ram.
`timescale 1ns / 1ps

// Circular message queue of up to 64 elements of 64 bits. Each input
// transaction is an enqueue, dequeue or queue reset (s_tuser; the unused code
// changes nothing) and yields exactly one result transaction with status,
// dequeued data, fill count and overflow state. The block takes one
// transaction per cycle as long as results are taken; a result passes through
// stage one, which holds the registered read of the element memory, and then
// the output register. The element memory is not cleared by reset and needs
// no clearing pass; the queue is usable as soon as reset is released. Write
// cfg_wdata with cfg_we only while no transaction is in flight.
module message_fifo_with_overflow_count (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Input stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [mfoc_pkg::DATA_W-1:0]          s_tdata,   // [63:0] data_in
	input  logic [mfoc_pkg::OP_W-1:0]            s_tuser,   // [1:0] operation
	// Result stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [63:0] data_out, [70:64] fill_count, [71] overflow_seen,
	// [103:72] overflow_total
	output logic [mfoc_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic [mfoc_pkg::ST_W-1:0]            m_tuser,   // [1:0] status
	// Configuration: queue_length
	input  logic                                 cfg_we,
	input  logic [mfoc_pkg::QLEN_W-1:0]          cfg_wdata
);
	import mfoc_pkg::*;

	ram_req_t          ram_req;
	meta_t             meta;
	logic [ELEM_W-1:0] ram_rdata;
	logic              accept;
	logic              valid_s1;
	meta_t             meta_s1;
	logic              advance_s1;
	logic              out_valid_q;
	logic [OUT_TDATA_W-1:0] out_tdata_q;
	logic [ST_W-1:0]   out_tuser_q;
	logic [DATA_W-1:0] data_out;
	logic [OUT_FIELDS_W-1:0] fields;

	// Handshake: the stage moves on whenever the output register is free or drains.
	assign advance_s1 = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready   = !valid_s1 || advance_s1;
	assign accept     = s_tvalid && s_tready;

	mfoc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.operation (s_tuser),
		.data_in   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ram_req   (ram_req),
		.meta      (meta)
	);

	mfoc_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	// Stage one waits for the memory read; the read data holds until the next read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= meta;
		end
	end

	// Assemble the result fields.
	assign data_out = meta_s1.rd_used ? DATA_W'(ram_rdata) : '0;
	assign fields   = {meta_s1.ovf_total, meta_s1.ovf_seen, FILL_W'(meta_s1.fill), data_out};

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			out_tdata_q <= OUT_TDATA_W'(fields);
			out_tuser_q <= meta_s1.status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_tdata_q;
	assign m_tuser  = out_tuser_q;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for message_fifo_with_overflow_count: directed table, then random
// phases at several queue lengths; each result is checked against a typed row or the in-bench model.
// Depends on mfoc_pkg and the message_fifo_with_overflow_count RTL.
`timescale 1ns / 1ps

module tb_top;
	import mfoc_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 60;
	localparam int LOG_CAP = 30;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam logic [ELEM_W-1:0] ALL_ONES = {ELEM_W{1'b1}};

	// Fields of one result transaction.
	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [ELEM_W-1:0] data;
		logic [FILL_W-1:0] fill;
		logic              ovf_seen;
		logic [OVF_W-1:0]  ovf_total;
	} queue_result_t;

	typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

	// One row of the directed table; for a length write, value holds the length.
	typedef struct packed {
		row_kind_t         kind;
		logic [OP_W-1:0]   op;
		logic [ELEM_W-1:0] value;
		logic              typed;
		queue_result_t     want;
	} dir_row_t;

	localparam queue_result_t NO_RES = '0;

	localparam dir_row_t DIR_ROWS [31] = '{
		// Empty dequeue and unused code right after reset.
		'{ROW_ITEM, OP_DEQUEUE, 64'h0, 1'b1, '{ST_EMPTY, 64'h0, 7'd0, 1'b0, 32'd0}},
		'{ROW_ITEM, OP_UNUSED, ALL_ONES, 1'b1, '{ST_OK, 64'h0, 7'd0, 1'b0, 32'd0}},
		// Length zero behaves as one slot.
		'{ROW_CFG, OP_ENQUEUE, 64'd0, 1'b0, NO_RES},
		'{ROW_ITEM, OP_ENQUEUE, ALL_ONES, 1'b1, '{ST_OK, 64'h0, 7'd1, 1'b0, 32'd0}},
		'{ROW_ITEM, OP_ENQUEUE, 64'h0, 1'b1, '{ST_FULL, 64'h0, 7'd1, 1'b1, 32'd1}},
		'{ROW_ITEM, OP_DEQUEUE, 64'h0, 1'b1, '{ST_OK, ALL_ONES, 7'd0, 1'b1, 32'd1}},
		'{ROW_ITEM, OP_RESET, ALL_ONES, 1'b1, '{ST_OK, 64'h0, 7'd0, 1'b0, 32'd0}},
		// Fill a three-slot queue past full and drain part of it.
		'{ROW_CFG, OP_ENQUEUE, 64'd3, 1'b0, NO_RES},
		'{ROW_ITEM, OP_ENQUEUE, 64'h0123_4567_89ab_cdef, 1'b0, NO_RES},
		'{ROW_ITEM, OP_ENQUEUE, 64'ha5a5_a5a5_a5a5_a5a5, 1'b0, NO_RES},
		'{ROW_ITEM, OP_ENQUEUE, 64'h5a5a_5a5a_5a5a_5a5a, 1'b0, NO_RES},
		'{ROW_ITEM, OP_ENQUEUE, 64'h8000_0000_0000_0001, 1'b0, NO_RES},
		'{ROW_ITEM, OP_DEQUEUE, 64'h0, 1'b0, NO_RES},
		'{ROW_ITEM, OP_DEQUEUE, 64'h0, 1'b0, NO_RES},
		// Shrink to two slots with the read pointer beyond the new length.
		'{ROW_CFG, OP_ENQUEUE, 64'd2, 1'b0, NO_RES},
		'{ROW_ITEM, OP_ENQUEUE, 64'h0000_0000_0000_0001, 1'b0, NO_RES},
		'{ROW_ITEM, OP_ENQUEUE, 64'hffff_ffff_ffff_fffe, 1'b0, NO_RES},
		'{ROW_ITEM, OP_DEQUEUE, 64'h0, 1'b0, NO_RES},
		'{ROW_ITEM, OP_DEQUEUE, 64'h0, 1'b0, NO_RES},
		'{ROW_ITEM, OP_DEQUEUE, 64'h0, 1'b0, NO_RES},
		// Length above the built depth is clamped to the depth.
		'{ROW_CFG, OP_ENQUEUE, 64'd127, 1'b0, NO_RES},
		'{ROW_ITEM, OP_ENQUEUE, 64'h7fff_ffff_ffff_ffff, 1'b0, NO_RES},
		'{ROW_ITEM, OP_ENQUEUE, 64'h1, 1'b0, NO_RES},
		'{ROW_ITEM, OP_ENQUEUE, 64'h2, 1'b0, NO_RES},
		// Count above a reduced length answers full; drain wraps onto an old slot.
		'{ROW_CFG, OP_ENQUEUE, 64'd2, 1'b0, NO_RES},
		'{ROW_ITEM, OP_ENQUEUE, 64'h3, 1'b0, NO_RES},
		'{ROW_ITEM, OP_DEQUEUE, 64'h0, 1'b0, NO_RES},
		'{ROW_ITEM, OP_DEQUEUE, 64'h0, 1'b0, NO_RES},
		'{ROW_ITEM, OP_DEQUEUE, 64'h0, 1'b0, NO_RES},
		'{ROW_ITEM, OP_DEQUEUE, 64'h0, 1'b0, NO_RES},
		'{ROW_ITEM, OP_RESET, 64'h0, 1'b0, NO_RES}
	};

	localparam int PHASE_LEN [PHASES] = '{64, 1, 5, 64, 0, 2, 127, 3, 100, 0, 64, 8};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [DATA_W-1:0]      s_tdata = '0;
	logic [OP_W-1:0]        s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [ST_W-1:0]        m_tuser;
	logic                   cfg_we = 1'b0;
	logic [QLEN_W-1:0]      cfg_wdata = '0;

	message_fifo_with_overflow_count dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow copy of the queue state.
	logic [ELEM_W-1:0] shadow_store [DEPTH];
	bit                shadow_written [DEPTH];
	int                shadow_rd = 0;
	int                shadow_wr = 0;
	int                shadow_count = 0;
	logic              shadow_ovf = 1'b0;
	logic [OVF_W-1:0]  shadow_ovf_total = '0;
	logic [QLEN_W-1:0] shadow_len = QLEN_RESET;

	queue_result_t pending_results [$];
	int  fault_count = 0;
	int  items_sent = 0;
	int  results_seen = 0;
	int  full_seen = 0;
	int  empty_seen = 0;
	int  cycles = 0;
	int  burst_left = 0;
	bit  gapless = 1'b0;
	int  hold_len = 0;

	function automatic int slot_after(int p, int len);
		return (p + 1 >= len) ? 0 : p + 1;
	endfunction

	// Applies one operation to the shadow queue and returns the result it answers.
	function automatic queue_result_t queue_apply(logic [OP_W-1:0] op, logic [ELEM_W-1:0] din);
		queue_result_t r;
		int len;
		len = (shadow_len == 0) ? 1 : (shadow_len > DEPTH) ? DEPTH : int'(shadow_len);
		r = '0;
		r.status = ST_OK;
		case (op)
			OP_ENQUEUE: begin
				if (shadow_count < len) begin
					if (shadow_count != 0)
						shadow_wr = slot_after(shadow_wr, len);
					else
						shadow_rd = shadow_wr;
					shadow_store[shadow_wr] = din;
					shadow_written[shadow_wr] = 1'b1;
					shadow_count++;
				end else begin
					shadow_ovf_total++;
					shadow_ovf = 1'b1;
					r.status = ST_FULL;
				end
			end
			OP_DEQUEUE: begin
				if (shadow_count > 0) begin
					r.data = shadow_store[shadow_rd];
					shadow_rd = slot_after(shadow_rd, len);
					shadow_count--;
				end else begin
					r.status = ST_EMPTY;
				end
			end
			OP_RESET: begin
				shadow_count = 0;
				shadow_rd = 0;
				shadow_wr = 0;
				shadow_ovf = 1'b0;
				shadow_ovf_total = '0;
			end
			default: ;
		endcase
		r.fill = FILL_W'(shadow_count);
		r.ovf_seen = shadow_ovf;
		r.ovf_total = shadow_ovf_total;
		return r;
	endfunction

	// Offers one transaction, in bursts with random gaps unless gapless is set, and records its result.
	task automatic offer(input logic [OP_W-1:0] op, input logic [ELEM_W-1:0] din,
			input logic typed, input queue_result_t typed_want);
		queue_result_t want;
		if (!gapless && burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= din;
		do @(posedge clk); while (!s_tready);
		if (burst_left > 0)
			burst_left--;
		want = queue_apply(op, din);
		pending_results.push_back(typed ? typed_want : want);
		items_sent++;
	endtask

	// Stops offering and waits until every expected result has arrived.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Writes the queue length while the block is idle.
	task automatic write_length(input logic [QLEN_W-1:0] len);
		drain();
		cfg_wdata <= len;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_len = len;
	endtask

	task automatic flag_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			if (fault_count < LOG_CAP)
				$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
					$time, name, want, got);
			fault_count++;
		end
	endtask

	// Receiver: random stall pattern, picked anew as the cycle counter runs; a long hold-off on request.
	initial begin
		int mode;
		int n;
		mode = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_len != 0) begin
				n = hold_len;
				hold_len = 0;
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			if (cycles % 64 == 0)
				mode = $urandom_range(0, 3);
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 1) == 0);
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// Compares each accepted result transaction with the oldest expectation.
	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (m_tuser == ST_FULL)
				full_seen++;
			if (m_tuser == ST_EMPTY)
				empty_seen++;
			if (pending_results.size() == 0) begin
				if (fault_count < LOG_CAP)
					$display("%0t ns: unexpected result, actual status 0x%0h data 0x%0h",
						$time, m_tuser, m_tdata[63:0]);
				fault_count++;
			end else begin
				want = pending_results.pop_front();
				flag_field("status", 64'(want.status), 64'(m_tuser));
				flag_field("data_out", want.data, m_tdata[63:0]);
				flag_field("fill_count", 64'(want.fill), 64'(m_tdata[70:64]));
				flag_field("overflow_seen", 64'(want.ovf_seen), 64'(m_tdata[71]));
				flag_field("overflow_total", 64'(want.ovf_total), 64'(m_tdata[103:72]));
			end
		end
	end

	// Cycle counter and timeout.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, pending_results.size());
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// Stimulus: directed table, then random phases at different queue lengths.
	initial begin
		logic [OP_W-1:0] op;
		logic [ELEM_W-1:0] din;
		int enq_pct;
		int pick;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_ROWS[i]) begin
			if (DIR_ROWS[i].kind == ROW_CFG)
				write_length(DIR_ROWS[i].value[QLEN_W-1:0]);
			else
				offer(DIR_ROWS[i].op, DIR_ROWS[i].value, DIR_ROWS[i].typed,
					DIR_ROWS[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			write_length((p == 9) ? QLEN_W'($urandom_range(1, 64)) : QLEN_W'(PHASE_LEN[p]));
			gapless = (p == 3) || ($urandom_range(0, 3) == 0);
			enq_pct = (p == 3) ? 70 : $urandom_range(30, 80);
			// Long receiver hold-off while the sender keeps offering.
			if (p == 3)
				hold_len = 300;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 2)
					op = OP_RESET;
				else if (pick < 4)
					op = OP_UNUSED;
				else if (pick < 4 + enq_pct)
					op = OP_ENQUEUE;
				else
					op = OP_DEQUEUE;
				// Never dequeue a slot that was never written.
				if (op == OP_DEQUEUE && shadow_count != 0 && !shadow_written[shadow_rd])
					op = OP_ENQUEUE;
				case ($urandom_range(0, 9))
					0: din = ALL_ONES;
					1: din = '0;
					default: din = {$urandom, $urandom};
				endcase
				offer(op, din, 1'b0, NO_RES);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Sent %0d transactions over %0d length settings; %0d results checked,",
			items_sent, PHASES + 5, results_seen);
		$display("including %0d full and %0d empty answers, with %0d mismatches.",
			full_seen, empty_seen, fault_count);
		if (fault_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// File: sim.f
rtl/mfoc_pkg.sv
rtl/mfoc_ram.sv
rtl/mfoc_ctrl.sv
rtl/message_fifo_with_overflow_count.sv
tb/sv/tb_top.sv
